// ===== hw/rtl/prc_pkg.sv =====
// Shared constants and types for the 2bpp polyline rasterizer.
// No dependencies; compiled first.
`default_nettype none

package prc_pkg;

    localparam int FRAME_SIDE_DEF = 200;
    localparam int COORD_W        = 16;
    localparam int ACC_W          = 36;  // numerator width for the start divide

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_MOVE  = 2'd1;
    localparam t_cmd CMD_LINE  = 2'd2;
    localparam t_cmd CMD_READ  = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/prc_if.sv =====
// Valid/ready channel interfaces for the polyline rasterizer.
// Depends on prc_pkg.
`default_nettype none

interface prc_cmd_if;
    import prc_pkg::*;
    logic                       valid;
    logic                       ready;
    t_cmd                       command;
    logic signed [COORD_W-1:0]  vertex_x;
    logic signed [COORD_W-1:0]  vertex_y;
    modport source (output valid, command, vertex_x, vertex_y, input ready);
    modport sink   (input valid, command, vertex_x, vertex_y, output ready);
endinterface

interface prc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    modport source (output valid, read_byte, input ready);
    modport sink   (input valid, read_byte, output ready);
endinterface

interface prc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] draw_color;
    modport source (output valid, draw_color, input ready);
    modport sink   (input valid, draw_color, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/polyline_raster_2bpp_core.sv =====
// Polyline rasterizer core with an on-chip 2bpp frame store.
// Depends on prc_pkg and the channel interfaces in prc_if.sv.
//
// Usage:
//   i_cmd_ch  : command words (clear, move, line, read byte) with a vertex.
//   o_byte_ch : one word per read command, the addressed store byte.
//   i_cfg_ch  : draw color, always ready; write it only while idle.
// After reset the store is swept to zero, one byte a cycle, so the
// command channel stays not ready until all FRAME_SIDE*ceil(FRAME_SIDE/4)
// bytes (10000 at the default size) are cleared. A clear command takes
// the same sweep. A read passes through S_RRD and then S_RESP, which
// puts its word in the output register.
// A line sets up, runs one multiplier twice, then a restoring divide for
// the first minor coordinate; after that the minor value is stepped by
// add/compare, with a read-modify-write (S_PRD, then S_PWR) per plotted
// pixel. The major axis is clipped to the frame before the walk, so
// off-frame parts of the major range are not walked.
// One command is in work at a time; the command channel is ready only idle.
// If the receiver stalls, the word holds in the output register; later
// commands are still taken, but a further read waits in its last cycle
// (not ready) until the register is free.
`default_nettype none

module polyline_raster_2bpp_core #(
    parameter int FRAME_SIDE = prc_pkg::FRAME_SIDE_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    prc_cmd_if.sink   i_cmd_ch,
    prc_byte_if.source o_byte_ch,
    prc_cfg_if.sink   i_cfg_ch
);
    import prc_pkg::*;

    localparam int ROW_BYTES   = (FRAME_SIDE + 3) / 4;
    localparam int STORE_BYTES = FRAME_SIDE * ROW_BYTES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = $clog2(FRAME_SIDE + 1);
    localparam int DCW         = $clog2(ACC_W);
    localparam logic signed [17:0] SIDE_S = 18'(FRAME_SIDE);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SETUP, S_MUL1, S_MUL2, S_ABS, S_DIV, S_FIX,
        S_PRD, S_PWR, S_RRD, S_RESP
    } t_state;

    t_state r_state;

    logic [1:0]                r_color;
    logic signed [COORD_W-1:0] r_last_x, r_last_y, r_vx, r_vy;
    logic [AW-1:0]             r_clr_addr;

    // segment parameters
    logic                r_xmaj;
    logic signed [17:0]  r_m1, r_s;
    logic [16:0]         r_d;
    logic [17:0]         r_k;
    logic [CW-1:0]       r_i, r_end;

    // divide
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_neg;
    logic [ACC_W-1:0]        r_dvd;
    logic [16:0]             r_rem;
    logic [DCW-1:0]          r_cnt;

    // running minor value: floor quotient and remainder
    logic signed [17:0] r_q;
    logic signed [18:0] r_r;

    logic [AW-1:0] r_addr;
    logic [1:0]    r_sh;
    logic [7:0]    r_rdata;
    logic          r_rd_ok;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;

    logic [7:0] r_mem [STORE_BYTES];

    assign i_cmd_ch.ready    = (r_state == S_IDLE);
    assign i_cfg_ch.ready    = 1'b1;
    assign o_byte_ch.valid   = r_out_valid;
    assign o_byte_ch.read_byte = r_out_byte;

    // ---- segment setup: pick major axis, order ends, clip major range
    logic signed [17:0] x1, y1, x2, y2, dx, dy, adx, ady;
    logic signed [17:0] su_a, su_b, su_m1, su_mf, su_start, su_fin;
    logic               su_xmaj, su_swap;
    logic [16:0]        su_d;

    always_comb begin
        x1 = 18'(r_last_x);
        y1 = 18'(r_last_y);
        x2 = 18'(r_vx);
        y2 = 18'(r_vy);
        dx = x2 - x1;
        dy = y2 - y1;
        adx = dx[17] ? -dx : dx;
        ady = dy[17] ? -dy : dy;
        su_xmaj = (dx != 18'sd0) && (ady <= adx);
        if (su_xmaj) begin
            su_swap = x1 > x2;
            su_a  = su_swap ? x2 : x1;
            su_b  = su_swap ? x1 : x2;
            su_m1 = su_swap ? y2 : y1;
            su_mf = su_swap ? y1 : y2;
            su_d  = adx[16:0];
        end else begin
            su_swap = y1 > y2;
            su_a  = su_swap ? y2 : y1;
            su_b  = su_swap ? y1 : y2;
            su_m1 = su_swap ? x2 : x1;
            su_mf = su_swap ? x1 : x2;
            su_d  = ady[16:0];
        end
        su_start = su_a[17] ? 18'sd0 : su_a;
        su_fin   = (su_b > SIDE_S) ? SIDE_S : su_b;
    end

    // ---- shared multiplier
    logic signed [17:0]      mul_a, mul_b;
    logic signed [ACC_W-1:0] prod;

    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = r_m1;
            mul_b = $signed({1'b0, r_d});
        end else begin
            mul_a = $signed(r_k);
            mul_b = r_s;
        end
        prod = mul_a * mul_b;
    end

    // ---- restoring divide step
    logic [17:0] dv_trial;
    logic        dv_ge;
    always_comb begin
        dv_trial = {r_rem, r_dvd[ACC_W-1]};
        dv_ge    = dv_trial >= {1'b0, r_d};
    end

    // ---- fix floor quotient for negative numerators
    logic signed [17:0] qa;
    always_comb qa = $signed(r_dvd[17:0]);

    // ---- pixel: round half away from zero, then address
    logic               bump, pix_in;
    logic signed [17:0] minor_v;
    logic [CW-1:0]      px, py;
    logic [AW-1:0]      pix_addr;
    logic signed [18:0] nr_sum, r2, d19;
    logic signed [18:0] adv_r;
    logic signed [17:0] adv_q;
    logic [CW-1:0]      adv_i;

    always_comb begin
        d19  = $signed({2'b00, r_d});
        r2   = r_r <<< 1;
        bump = r_q[17] ? (r2 > d19) : (r2 >= d19);
        minor_v = r_q + 18'(bump);
        pix_in  = !minor_v[17] && (minor_v < SIDE_S);
        px = r_xmaj ? r_i : minor_v[CW-1:0];
        py = r_xmaj ? minor_v[CW-1:0] : r_i;
        pix_addr = AW'(32'(py) * ROW_BYTES + 32'(px >> 2));

        adv_i  = r_i + CW'(1);
        nr_sum = r_r + 19'(r_s);
        if (nr_sum >= d19) begin
            adv_r = nr_sum - d19;
            adv_q = r_q + 18'sd1;
        end else if (nr_sum[18]) begin
            adv_r = nr_sum + d19;
            adv_q = r_q - 18'sd1;
        end else begin
            adv_r = nr_sum;
            adv_q = r_q;
        end
    end

    // ---- read command address
    logic          rd_ok;
    logic [AW-1:0] rd_addr;
    always_comb begin
        rd_ok = !r_vx[15] && (32'(r_vx) < ROW_BYTES) &&
                !r_vy[15] && (32'(r_vy) < FRAME_SIDE);
        rd_addr = AW'(32'(unsigned'(r_vy)) * ROW_BYTES + 32'(unsigned'(r_vx)));
    end

    // ---- store port control
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = (r_rdata & ~(8'd3 << {r_sh, 1'b0})) |
                    (8'(r_color) << {r_sh, 1'b0});
        if (r_state == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'd0;
        end else if (r_state == S_PWR) begin
            mem_we = 1'b1;
        end
        mem_re    = (r_state == S_RRD) || (r_state == S_PRD);
        mem_raddr = (r_state == S_RRD) ? rd_addr : pix_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_color     <= 2'd1;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_ch.valid) begin
                r_color <= i_cfg_ch.draw_color;
            end
            // S_RESP handles the output register itself
            if (r_out_valid && o_byte_ch.ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(STORE_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_ch.valid) begin
                        r_vx <= i_cmd_ch.vertex_x;
                        r_vy <= i_cmd_ch.vertex_y;
                        unique case (i_cmd_ch.command)
                            CMD_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= S_CLR;
                            end
                            CMD_MOVE: begin
                                r_last_x <= i_cmd_ch.vertex_x;
                                r_last_y <= i_cmd_ch.vertex_y;
                            end
                            CMD_LINE: r_state <= S_SETUP;
                            default:  r_state <= S_RRD;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_last_x <= r_vx;
                    r_last_y <= r_vy;
                    r_xmaj   <= su_xmaj;
                    r_m1     <= su_m1;
                    r_s      <= su_mf - su_m1;
                    r_d      <= su_d;
                    r_k      <= 18'(su_start - su_a);
                    r_i      <= su_start[CW-1:0];
                    r_end    <= su_fin[CW-1:0];
                    r_state  <= (su_start >= su_fin) ? S_IDLE : S_MUL1;
                end
                S_MUL1: begin
                    r_acc   <= prod;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= r_acc + prod;
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_neg   <= r_acc[ACC_W-1];
                    r_dvd   <= r_acc[ACC_W-1] ? unsigned'(-r_acc) : unsigned'(r_acc);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= dv_ge ? 17'(dv_trial - {1'b0, r_d}) : dv_trial[16:0];
                    r_dvd <= {r_dvd[ACC_W-2:0], dv_ge};
                    r_cnt <= r_cnt + DCW'(1);
                    if (r_cnt == DCW'(ACC_W - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (r_neg && (r_rem != '0)) begin
                        r_q <= -qa - 18'sd1;
                        r_r <= $signed({2'b00, r_d - r_rem});
                    end else begin
                        r_q <= r_neg ? -qa : qa;
                        r_r <= $signed({2'b00, r_rem});
                    end
                    r_state <= S_PRD;
                end
                S_PRD: begin
                    if (pix_in) begin
                        r_addr  <= pix_addr;
                        r_sh    <= px[1:0];
                        r_state <= S_PWR;
                    end else begin
                        r_i     <= adv_i;
                        r_q     <= adv_q;
                        r_r     <= adv_r;
                        r_state <= (adv_i == r_end) ? S_IDLE : S_PRD;
                    end
                end
                S_PWR: begin
                    r_i     <= adv_i;
                    r_q     <= adv_q;
                    r_r     <= adv_r;
                    r_state <= (adv_i == r_end) ? S_IDLE : S_PRD;
                end
                S_RRD: begin
                    r_rd_ok <= rd_ok;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // register free, or its word leaves this edge
                    if (!r_out_valid || o_byte_ch.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_rd_ok ? r_rdata : 8'd0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/polyline_raster_2bpp_core_tb.sv =====
// Self-checking testbench for polyline_raster_2bpp_core: drives draw commands and byte reads,
// predicts store contents in a local frame image and checks every read word.
// Depends on prc_pkg, the channel interfaces in prc_if.sv and the core RTL.
`timescale 1ns / 1ps

module polyline_raster_2bpp_core_tb;
    import prc_pkg::*;

    localparam int SIDE      = FRAME_SIDE_DEF;
    localparam int ROW_BYTES = (SIDE + 3) / 4;
    localparam int N_BYTES   = SIDE * ROW_BYTES;

    logic i_clk;
    logic i_rst_n;

    prc_cmd_if  cmd_ch ();
    prc_byte_if byte_ch ();
    prc_cfg_if  cfg_ch ();

    polyline_raster_2bpp_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_ch  (cmd_ch),
        .o_byte_ch (byte_ch),
        .i_cfg_ch  (cfg_ch)
    );

    // Predicted frame image and pen state.
    logic [7:0]        img [N_BYTES];
    logic signed [15:0] pen_x, pen_y;
    logic [1:0]        pen_color;
    logic [7:0]        byte_q [$];   // expected read words, oldest first

    int errors;
    int send_idle_pct, recv_idle_pct;
    int hold_cycles;   // receiver hold-off requested by the stimulus process

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop: sized for the clear sweeps and the line walks, with slack.
    initial begin
        #40ms;
        $display("polyline_raster_2bpp_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        $display("MISMATCH %s: got %02h want %02h at %0t", what, got, want, $realtime);
    endtask

    // Rounded quotient, half away from zero; den > 0.
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0) return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    function automatic void set_pixel(input longint x, input longint y);
        int sh, a;
        if (x < 0 || x >= SIDE || y < 0 || y >= SIDE) return;
        sh = int'(x % 4) * 2;
        a  = int'(y) * ROW_BYTES + int'(x / 4);
        img[a] = (img[a] & ~(8'd3 << sh)) | (8'(pen_color) << sh);
    endfunction

    function automatic void draw_segment(input longint ax, input longint ay,
                                         input longint bx, input longint by);
        longint t, dx, dy, ady, lo, hi;
        if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx  = bx - ax;
        dy  = by - ay;
        ady = dy < 0 ? -dy : dy;
        if (dx == 0) begin
            // vertical: bottom-up regardless of direction
            lo = ay < by ? ay : by;
            hi = ay < by ? by : ay;
            for (longint i = lo; i < hi; i++) set_pixel(ax, i);
        end else if (ady > dx) begin
            // y-major: walk from the lower row
            if (ay > by) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx = bx - ax;
            dy = by - ay;
            for (longint i = ay; i < by; i++)
                set_pixel(round_div(ax * dy + (i - ay) * dx, dy), i);
        end else begin
            // x-major, slope of exactly one lands here too
            for (longint i = ax; i < bx; i++)
                set_pixel(i, round_div(ay * dx + (i - ax) * dy, dx));
        end
    endfunction

    // Apply one accepted command word to the predicted state.
    function automatic void predict_cmd(input t_cmd c, input logic signed [15:0] vx,
                                        input logic signed [15:0] vy);
        case (c)
            CMD_CLEAR: foreach (img[k]) img[k] = 8'h00;
            CMD_MOVE: begin
                pen_x = vx;
                pen_y = vy;
            end
            CMD_LINE: begin
                draw_segment(pen_x, pen_y, vx, vy);
                pen_x = vx;
                pen_y = vy;
            end
            default: begin
                if (vx >= 0 && vx < ROW_BYTES && vy >= 0 && vy < SIDE)
                    byte_q.push_back(img[int'(vy) * ROW_BYTES + int'(vx)]);
                else
                    byte_q.push_back(8'h00);
            end
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off when asked.
    initial begin
        byte_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                byte_ch.ready <= 1'b0;
            end else begin
                byte_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Checker: compares every accepted read word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            if (byte_q.size() == 0) begin
                report_mismatch("unexpected word", byte_ch.read_byte, 8'h00);
            end else begin
                logic [7:0] want;
                want = byte_q.pop_front();
                if (byte_ch.read_byte !== want)
                    report_mismatch("read_byte", byte_ch.read_byte, want);
            end
        end
    end

    // Sends one command word; valid drops only while the sender idles.
    task automatic send_cmd(input t_cmd c, input logic signed [15:0] vx,
                            input logic signed [15:0] vy);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= c;
        cmd_ch.vertex_x <= vx;
        cmd_ch.vertex_y <= vy;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_cmd(c, vx, vy);
    endtask

    // Waits until every word is back and the block is idle again.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (byte_q.size() != 0 || !cmd_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [1:0] c);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.draw_color <= c;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        pen_color = c;
    endtask

    // Random coordinate: mostly in or near the frame, sometimes anywhere.
    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(9))
            0:       return 16'($urandom());
            1:       return 16'($urandom_range(SIDE + 40)) - 16'sd20;
            default: return 16'($urandom_range(SIDE - 1));
        endcase
    endfunction

    typedef struct {
        t_cmd              c;
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                typed;   // expected word written in the table
        logic [7:0]        want;
    } t_row;

    t_row rows [$];

    task automatic run_rows();
        foreach (rows[r]) begin
            send_cmd(rows[r].c, rows[r].x, rows[r].y);
            // typed words must agree with the image prediction
            if (rows[r].typed && byte_q[$] !== rows[r].want)
                report_mismatch("table", byte_q[$], rows[r].want);
        end
    endtask

    task automatic random_phase(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0:             send_cmd(CMD_CLEAR, rand_coord(), rand_coord());
                1, 2, 3:       send_cmd(CMD_MOVE, rand_coord(), rand_coord());
                4, 5, 6, 7, 8, 9, 10, 11:
                               send_cmd(CMD_LINE, rand_coord(), rand_coord());
                default: begin
                    // reads mostly in range, a few wild
                    if ($urandom_range(7) == 0)
                        send_cmd(CMD_READ, 16'($urandom()), 16'($urandom()));
                    else
                        send_cmd(CMD_READ, 16'($urandom_range(ROW_BYTES)),
                                 16'($urandom_range(SIDE)));
                end
            endcase
        end
    endtask

    initial begin
        errors         = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_cycles    = 0;
        pen_x          = '0;
        pen_y          = '0;
        pen_color      = 2'd1;
        foreach (img[k]) img[k] = 8'h00;
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_MOVE;
        cmd_ch.vertex_x    = '0;
        cmd_ch.vertex_y    = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.draw_color  = 2'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: after reset, edges, every command, special cases.
        rows = '{
            '{CMD_READ, 16'sd0, 16'sd0, 1'b1, 8'h00},
            '{CMD_READ, 16'sd49, 16'sd199, 1'b1, 8'h00},
            '{CMD_LINE, 16'sd4, 16'sd0, 1'b0, 8'h00},      // pen from reset origin
            '{CMD_READ, 16'sd0, 16'sd0, 1'b1, 8'h55},
            '{CMD_MOVE, 16'sd10, 16'sd20, 1'b0, 8'h00},
            '{CMD_LINE, 16'sd10, 16'sd10, 1'b0, 8'h00},    // vertical running upward
            '{CMD_READ, 16'sd2, 16'sd10, 1'b1, 8'h10},
            '{CMD_LINE, 16'sd10, 16'sd10, 1'b0, 8'h00},    // zero length
            '{CMD_LINE, 16'sd20, 16'sd20, 1'b0, 8'h00},    // slope one
            '{CMD_READ, 16'sd3, 16'sd11, 1'b0, 8'h00},
            '{CMD_MOVE, -16'sd32768, -16'sd32768, 1'b0, 8'h00},
            '{CMD_LINE, 16'sd32767, 16'sd32767, 1'b0, 8'h00}, // far outside, crosses frame
            '{CMD_READ, 16'sd0, 16'sd0, 1'b0, 8'h00},
            '{CMD_MOVE, 16'sd199, -16'sd5, 1'b0, 8'h00},
            '{CMD_LINE, 16'sd190, 16'sd205, 1'b0, 8'h00},  // steep, both ends clipped
            '{CMD_READ, 16'sd49, 16'sd199, 1'b0, 8'h00},
            '{CMD_READ, 16'sd50, 16'sd0, 1'b1, 8'h00},     // column out of range
            '{CMD_READ, -16'sd1, 16'sd0, 1'b1, 8'h00},
            '{CMD_READ, 16'sd0, 16'sd200, 1'b1, 8'h00},
            '{CMD_READ, 16'sd0, -16'sd32768, 1'b1, 8'h00},
            '{CMD_CLEAR, 16'sd0, 16'sd0, 1'b0, 8'h00},
            '{CMD_READ, 16'sd0, 16'sd0, 1'b1, 8'h00},
            '{CMD_LINE, 16'sd30, 16'sd30, 1'b0, 8'h00},    // pen survives clear
            '{CMD_READ, 16'sd5, 16'sd21, 1'b0, 8'h00}
        };
        run_rows();
        drain_results();

        // Phase 1: sender idles 30%, receiver 72%, color 3; long receiver hold.
        write_color(2'd3);
        send_idle_pct = 30;
        recv_idle_pct = 72;
        hold_cycles   = 3000;
        random_phase(100);
        drain_results();   // sender pauses until every word is back

        // Phase 2: roles swapped, color 0.
        write_color(2'd0);
        send_idle_pct = 72;
        recv_idle_pct = 30;
        random_phase(100);
        drain_results();

        // Phase 3: no idling, color 2.
        write_color(2'd2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(100);
        drain_results();

        if (errors == 0)
            $display("polyline_raster_2bpp_core verification clean");
        else
            $display("polyline_raster_2bpp_core verification failed");
        $finish;
    end

endmodule
